// ----- sv/tcfp_pkg.sv -----
package tcfp_pkg;

  // Parser phases; the numeric order matters for the body-end check
  typedef enum logic [3:0] {
    PH_TYPE         = 4'd0,
    PH_LEN          = 4'd1,
    PH_FIXED        = 4'd2,
    PH_SID_LEN      = 4'd3,
    PH_SID          = 4'd4,
    PH_CS_LEN       = 4'd5,
    PH_CS           = 4'd6,
    PH_COMP_LEN     = 4'd7,
    PH_COMP         = 4'd8,
    PH_EXT_TOTAL    = 4'd9,
    PH_EXT_HDR      = 4'd10,
    PH_EXT_LIST_LEN = 4'd11,
    PH_EXT_ITEMS    = 4'd12,
    PH_EXT_SKIP     = 4'd13,
    PH_DONE         = 4'd14
  } phase_t;

  // Result item tags
  typedef enum logic [2:0] {
    KIND_VERSION   = 3'd0,
    KIND_CIPHER    = 3'd1,
    KIND_EXTENSION = 3'd2,
    KIND_GROUP     = 3'd3,
    KIND_POINT     = 3'd4,
    KIND_SUPP_VER  = 3'd5,
    KIND_END       = 3'd6
  } kind_t;

  // End status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_CH    = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_MALFORMED = 2'd3
  } status_t;

  localparam logic [7:0]  HS_TYPE_CLIENT_HELLO = 8'd1;
  localparam logic [15:0] EXT_GROUPS           = 16'h000a;
  localparam logic [15:0] EXT_POINTS           = 16'h000b;
  localparam logic [15:0] EXT_VERSIONS         = 16'd43;
  // version (2) plus random (32)
  localparam int          FIXED_PART           = 2 + 32;

  // Results caused by one input byte: an optional value item, then an optional end item
  typedef struct packed {
    logic          val_vld;
    kind_t         kind;
    logic [15:0]   value;
    logic          end_vld;
    status_t       status;
  } res_entry_t;

  // GREASE: 0x?a?a with both bytes equal
  function automatic logic is_grease(input logic [15:0] v);
    is_grease = ((v & 16'h0f0f) == 16'h0a0a) && (v[15:8] == v[7:0]);
  endfunction

endpackage

// ----- sv/tls_client_hello_fingerprint_parser.sv -----
// TLS ClientHello field extractor.
// Input channel: one handshake message byte per item (in_data_byte), header
// first, with in_last_byte set on the final byte of the message. Output
// channel: tagged 16-bit values (version, ciphers, extension types, groups,
// point formats, supported versions) and, for the final byte, an end item
// with out_last_result set and the message status in out_status.
// Timing: a byte is parsed in the cycle it is accepted; its results show on
// the output channel from the next cycle. One byte is taken per cycle while
// in_stall is low; a byte causes at most two results (a value and the end
// item), given as two output items, the value first.
// Results wait in a 4-entry queue of per-byte result registers; in_stall
// rises only while that queue is full, so a stalled receiver backs up the
// input after four result-producing bytes.
// Reset (rst_n low, synchronous) empties the queue and returns the parser
// to the header type byte; the end item of each message does the same to
// the parser state.
module tls_client_hello_fingerprint_parser
  import tcfp_pkg::*;
#(
  parameter int LENGTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [15:0] out_value,
  output logic [1:0]  out_status,
  output logic        out_last_result
);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int OFF_W      = $clog2(FIXED_PART + 1);

  // Parser state
  phase_t                 phase_r, phase_nxt;
  logic [15:0]            hlen_r, hlen_nxt;
  logic [LENGTH_BITS-1:0] body_left_r, body_left_nxt;
  logic [OFF_W-1:0]       body_off_r, body_off_nxt;
  logic [15:0]            list_left_r, list_left_nxt;
  logic [15:0]            exts_left_r, exts_left_nxt;
  logic [15:0]            ext_left_r, ext_left_nxt;
  logic [15:0]            ext_type_r, ext_type_nxt;
  logic [7:0]             held_r, held_nxt;
  status_t                err_r, err_nxt;
  logic [1:0]             fpos_r, fpos_nxt;

  // Result queue
  res_entry_t             fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   sub_r, sub_nxt;

  logic                   in_acc;
  res_entry_t             new_ent;
  logic                   push;
  res_entry_t             head;
  logic                   show_val;
  logic                   pop_item;
  logic                   pop_entry;

  logic [LENGTH_BITS-1:0] rem;
  logic [15:0]            v;
  logic [15:0]            ext_left_old;
  logic [23:0]            hlen_full;

  assign in_stall = (cnt_r == CNT_W'(FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;

  // Parse one byte
  always_comb begin
    phase_nxt     = phase_r;
    hlen_nxt      = hlen_r;
    body_left_nxt = body_left_r;
    body_off_nxt  = body_off_r;
    list_left_nxt = list_left_r;
    exts_left_nxt = exts_left_r;
    ext_left_nxt  = ext_left_r;
    ext_type_nxt  = ext_type_r;
    held_nxt      = held_r;
    err_nxt       = err_r;
    fpos_nxt      = fpos_r;
    new_ent       = '0;
    rem           = body_left_r - 1'b1;
    v             = {held_r, in_data_byte};
    ext_left_old  = ext_left_r;
    hlen_full     = {hlen_r, in_data_byte};

    if (phase_r == PH_TYPE) begin
      if (in_data_byte != HS_TYPE_CLIENT_HELLO) begin
        err_nxt   = ST_NOT_CH;
        phase_nxt = PH_DONE;
      end else begin
        phase_nxt = PH_LEN;
        fpos_nxt  = 2'd0;
        hlen_nxt  = 16'd0;
      end
    end else if (phase_r == PH_LEN) begin
      hlen_nxt = hlen_full[15:0];
      if (fpos_r == 2'd2) begin
        fpos_nxt = 2'd0;
        if ((hlen_full >> LENGTH_BITS) != 24'd0 || hlen_full == 24'd0) begin
          err_nxt   = ST_MALFORMED;
          phase_nxt = PH_DONE;
        end else begin
          body_left_nxt = hlen_full[LENGTH_BITS-1:0];
          body_off_nxt  = '0;
          phase_nxt     = PH_FIXED;
        end
      end else begin
        fpos_nxt = fpos_r + 2'd1;
      end
    end else if (body_left_r != '0) begin
      body_left_nxt = rem;
      case (phase_r)
        PH_FIXED: begin
          body_off_nxt = body_off_r + 1'b1;
          if (body_off_r == OFF_W'(0)) begin
            held_nxt = in_data_byte;
          end else if (body_off_r == OFF_W'(1)) begin
            new_ent.val_vld = 1'b1;
            new_ent.kind    = KIND_VERSION;
            new_ent.value   = v;
          end
          if (body_off_r >= OFF_W'(FIXED_PART - 1)) begin
            phase_nxt = PH_SID_LEN;
          end
        end
        PH_SID_LEN, PH_COMP_LEN: begin
          fpos_nxt = 2'd0;
          if (LENGTH_BITS'(in_data_byte) > rem) begin
            err_nxt   = ST_MALFORMED;
            phase_nxt = PH_DONE;
          end else if (in_data_byte == 8'd0) begin
            phase_nxt = (phase_r == PH_SID_LEN) ? PH_CS_LEN : PH_EXT_TOTAL;
          end else begin
            list_left_nxt = {8'd0, in_data_byte};
            phase_nxt     = (phase_r == PH_SID_LEN) ? PH_SID : PH_COMP;
          end
        end
        PH_SID, PH_COMP: begin
          list_left_nxt = list_left_r - 16'd1;
          if (list_left_nxt == 16'd0) begin
            fpos_nxt  = 2'd0;
            phase_nxt = (phase_r == PH_SID) ? PH_CS_LEN : PH_EXT_TOTAL;
          end
        end
        PH_CS_LEN, PH_EXT_TOTAL: begin
          if (fpos_r == 2'd0) begin
            held_nxt = in_data_byte;
            fpos_nxt = 2'd1;
          end else begin
            fpos_nxt = 2'd0;
            if (phase_r == PH_EXT_TOTAL) begin
              if (LENGTH_BITS'(v) > rem) begin
                err_nxt   = ST_MALFORMED;
                phase_nxt = PH_DONE;
              end else begin
                exts_left_nxt = v;
                phase_nxt     = (v >= 16'd4) ? PH_EXT_HDR : PH_DONE;
              end
            end else if (v[0] || LENGTH_BITS'(v) > rem) begin
              err_nxt   = ST_MALFORMED;
              phase_nxt = PH_DONE;
            end else if (v == 16'd0) begin
              phase_nxt = PH_COMP_LEN;
            end else begin
              list_left_nxt = v;
              phase_nxt     = PH_CS;
            end
          end
        end
        PH_CS: begin
          if (fpos_r == 2'd0) begin
            held_nxt = in_data_byte;
            fpos_nxt = 2'd1;
          end else begin
            fpos_nxt = 2'd0;
            if (!is_grease(v)) begin
              new_ent.val_vld = 1'b1;
              new_ent.kind    = KIND_CIPHER;
              new_ent.value   = v;
            end
            list_left_nxt = (list_left_r >= 16'd2) ? list_left_r - 16'd2 : 16'd0;
            if (list_left_nxt == 16'd0) begin
              phase_nxt = PH_COMP_LEN;
            end
          end
        end
        PH_EXT_HDR: begin
          exts_left_nxt = exts_left_r - 16'd1;
          if (fpos_r == 2'd0 || fpos_r == 2'd2) begin
            held_nxt = in_data_byte;
            fpos_nxt = fpos_r + 2'd1;
          end else if (fpos_r == 2'd1) begin
            ext_type_nxt = v;
            fpos_nxt     = 2'd2;
          end else begin
            fpos_nxt = 2'd0;
            if (LENGTH_BITS'(v) > rem || v > exts_left_nxt) begin
              err_nxt   = ST_MALFORMED;
              phase_nxt = PH_DONE;
            end else begin
              // Start an extension of length v
              ext_left_nxt = v;
              if (is_grease(ext_type_r)) begin
                phase_nxt = PH_EXT_SKIP;
              end else begin
                new_ent.val_vld = 1'b1;
                new_ent.kind    = KIND_EXTENSION;
                new_ent.value   = ext_type_r;
                if (ext_type_r == EXT_GROUPS && v >= 16'd2) begin
                  phase_nxt = PH_EXT_LIST_LEN;
                end else if ((ext_type_r == EXT_POINTS || ext_type_r == EXT_VERSIONS)
                             && v >= 16'd1) begin
                  phase_nxt = PH_EXT_LIST_LEN;
                end else begin
                  phase_nxt = PH_EXT_SKIP;
                end
              end
              if (v == 16'd0) begin
                phase_nxt = (exts_left_nxt >= 16'd4) ? PH_EXT_HDR : PH_DONE;
              end
            end
          end
        end
        PH_EXT_LIST_LEN, PH_EXT_ITEMS, PH_EXT_SKIP: begin
          if (phase_r == PH_EXT_LIST_LEN) begin
            if (ext_type_r == EXT_GROUPS && fpos_r == 2'd0) begin
              held_nxt = in_data_byte;
              fpos_nxt = 2'd1;
            end else begin
              list_left_nxt = (ext_type_r == EXT_GROUPS) ? v : {8'd0, in_data_byte};
              fpos_nxt      = 2'd0;
              phase_nxt     = PH_EXT_ITEMS;
            end
          end else if (phase_r == PH_EXT_ITEMS) begin
            if (ext_type_r == EXT_POINTS) begin
              if (list_left_r >= 16'd1) begin
                new_ent.val_vld = 1'b1;
                new_ent.kind    = KIND_POINT;
                new_ent.value   = {8'd0, in_data_byte};
                list_left_nxt   = list_left_r - 16'd1;
              end else begin
                phase_nxt = PH_EXT_SKIP;
              end
            end else if (fpos_r == 2'd0) begin
              if (list_left_r >= ((ext_type_r == EXT_VERSIONS) ? 16'd2 : 16'd1)
                  && ext_left_old >= 16'd2) begin
                held_nxt = in_data_byte;
                fpos_nxt = 2'd1;
              end else begin
                phase_nxt = PH_EXT_SKIP;
              end
            end else begin
              fpos_nxt      = 2'd0;
              list_left_nxt = (list_left_r >= 16'd2) ? list_left_r - 16'd2 : 16'd0;
              if (ext_type_r == EXT_VERSIONS) begin
                new_ent.val_vld = 1'b1;
                new_ent.kind    = KIND_SUPP_VER;
                new_ent.value   = v;
              end else if (!is_grease(v)) begin
                new_ent.val_vld = 1'b1;
                new_ent.kind    = KIND_GROUP;
                new_ent.value   = v;
              end
            end
          end
          ext_left_nxt  = ext_left_r - 16'd1;
          exts_left_nxt = exts_left_r - 16'd1;
          // Move on to the next extension header, or finish
          if (ext_left_nxt == 16'd0) begin
            fpos_nxt  = 2'd0;
            phase_nxt = (exts_left_nxt >= 16'd4) ? PH_EXT_HDR : PH_DONE;
          end
        end
        default: begin
        end
      endcase

      // Body ended before the extensions length was read
      if (rem == '0 && phase_nxt < PH_EXT_HDR && err_nxt == ST_OK) begin
        err_nxt   = ST_MALFORMED;
        phase_nxt = PH_DONE;
      end
    end

    // Close the message on its last byte
    if (in_last_byte) begin
      new_ent.end_vld = 1'b1;
      if (err_nxt == ST_NOT_CH) begin
        new_ent.status = ST_NOT_CH;
      end else if (phase_nxt == PH_LEN || body_left_nxt != '0) begin
        new_ent.status = ST_TRUNCATED;
      end else begin
        new_ent.status = err_nxt;
      end
      phase_nxt     = PH_TYPE;
      hlen_nxt      = 16'd0;
      body_left_nxt = '0;
      body_off_nxt  = '0;
      list_left_nxt = 16'd0;
      exts_left_nxt = 16'd0;
      ext_left_nxt  = 16'd0;
      ext_type_nxt  = 16'd0;
      held_nxt      = 8'd0;
      err_nxt       = ST_OK;
      fpos_nxt      = 2'd0;
    end
  end

  // Advance parser state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      hlen_r      <= 16'd0;
      body_left_r <= '0;
      body_off_r  <= '0;
      list_left_r <= 16'd0;
      exts_left_r <= 16'd0;
      ext_left_r  <= 16'd0;
      ext_type_r  <= 16'd0;
      held_r      <= 8'd0;
      err_r       <= ST_OK;
      fpos_r      <= 2'd0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      hlen_r      <= hlen_nxt;
      body_left_r <= body_left_nxt;
      body_off_r  <= body_off_nxt;
      list_left_r <= list_left_nxt;
      exts_left_r <= exts_left_nxt;
      ext_left_r  <= ext_left_nxt;
      ext_type_r  <= ext_type_nxt;
      held_r      <= held_nxt;
      err_r       <= err_nxt;
      fpos_r      <= fpos_nxt;
    end
  end

  // Output side: value item first, then the end item of the same byte
  assign push      = in_acc && (new_ent.val_vld || new_ent.end_vld);
  assign head      = fifo_r[rd_ptr_r];
  assign out_valid = (cnt_r != '0);
  assign show_val  = head.val_vld && !sub_r;
  assign pop_item  = out_valid && !out_stall;
  assign pop_entry = pop_item && (!show_val || !head.end_vld);

  assign out_kind        = show_val ? head.kind : KIND_END;
  assign out_value       = show_val ? head.value : 16'd0;
  assign out_status      = show_val ? ST_OK : head.status;
  assign out_last_result = !show_val;

  always_comb begin
    sub_nxt = sub_r;
    if (pop_entry) begin
      sub_nxt = 1'b0;
    end else if (pop_item) begin
      sub_nxt = 1'b1;
    end
  end

  // Store result entries
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= new_ent;
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      sub_r    <= 1'b0;
    end else begin
      sub_r <= sub_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop_entry) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop_entry) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop_entry) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Checks
  a_last_resets_parser: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_byte) |=> (phase_r == PH_TYPE))
    else $error("parser not back at header type after last byte");

  a_idle_state_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TYPE) |-> (body_left_r == '0 && err_r == ST_OK))
    else $error("stale body count or error at message start");

  a_end_item_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |-> (out_kind == KIND_END && out_value == 16'd0))
    else $error("end item carries a value or a wrong tag");

  a_no_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (head.val_vld || head.end_vld))
    else $error("queued entry holds no result");

endmodule

// ----- bench/tb_tls_client_hello_fingerprint_parser.sv -----
module tb_tls_client_hello_fingerprint_parser
  import tcfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          LENGTH_BITS  = 24;
  localparam logic [31:0] LEN_LIMIT    = (32'd1 << LENGTH_BITS) - 32'd1;
  localparam int          RANDOM_BYTES = 500;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } hello_byte_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] value;
    status_t     status;
    logic        last;
  } hello_field_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_kind;
  logic [15:0] out_value;
  logic [1:0]  out_status;
  logic        out_last_result;

  // Stimulus and expectation stores
  hello_byte_t  pending_bytes[$];
  hello_field_t expected_fields[$];
  logic [7:0]   msg_q[$];
  hello_byte_t  next_byte;

  int unsigned bytes_sent = 0;
  int unsigned results_checked = 0;
  int unsigned messages_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned directed_count;

  // Parser shadow state
  phase_t      ph;
  logic [23:0] hdr_len;
  logic [23:0] body_left;
  logic [23:0] body_off;
  logic [15:0] list_left;
  logic [15:0] exts_left;
  logic [15:0] ext_left;
  logic [15:0] ext_type;
  logic [7:0]  high_byte;
  status_t     err;
  logic [1:0]  fpos;

  tls_client_hello_fingerprint_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_last_result(out_last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit grease_value(logic [15:0] v);
    return (v[11:8] == 4'ha) && (v[3:0] == 4'ha) && (v[15:12] == v[7:4]);
  endfunction

  function automatic void push_field(kind_t k, logic [15:0] v, status_t s, logic l);
    hello_field_t f;
    f.kind   = k;
    f.value  = v;
    f.status = s;
    f.last   = l;
    expected_fields.insert(expected_fields.size(), f);
  endfunction

  function automatic void reset_parser();
    ph        = PH_TYPE;
    hdr_len   = '0;
    body_left = '0;
    body_off  = '0;
    list_left = '0;
    exts_left = '0;
    ext_left  = '0;
    ext_type  = '0;
    high_byte = '0;
    err       = ST_OK;
    fpos      = '0;
  endfunction

  // Mark the body bad and stop extracting
  function automatic void end_body_parse();
    err = ST_MALFORMED;
    ph  = PH_DONE;
  endfunction

  // Move to the next extension header, or quit if too little is left
  function automatic void advance_extension();
    fpos = '0;
    ph   = (exts_left >= 16'd4) ? PH_EXT_HDR : PH_DONE;
  endfunction

  function automatic void hello_body_byte(logic [7:0] b);
    logic [23:0] idx;
    logic [23:0] rem;
    logic [15:0] v;
    logic [15:0] ext_before;
    logic [15:0] need;
    idx       = body_off;
    body_off  = body_off + 24'd1;
    body_left = body_left - 24'd1;
    rem       = body_left;
    case (ph)
      PH_FIXED: begin
        if (idx == 24'd0) high_byte = b;
        else if (idx == 24'd1) push_field(KIND_VERSION, {high_byte, b}, ST_OK, 1'b0);
        if (idx >= FIXED_PART - 1) ph = PH_SID_LEN;
      end
      PH_SID_LEN, PH_COMP_LEN: begin
        fpos = '0;
        if (b > rem) end_body_parse();
        else if (b == 8'd0) ph = (ph == PH_SID_LEN) ? PH_CS_LEN : PH_EXT_TOTAL;
        else begin
          list_left = {8'h00, b};
          ph = (ph == PH_SID_LEN) ? PH_SID : PH_COMP;
        end
      end
      PH_SID, PH_COMP: begin
        list_left = list_left - 16'd1;
        if (list_left == 16'd0) begin
          fpos = '0;
          ph = (ph == PH_SID) ? PH_CS_LEN : PH_EXT_TOTAL;
        end
      end
      PH_CS_LEN, PH_EXT_TOTAL: begin
        if (fpos == 2'd0) begin
          high_byte = b;
          fpos = 2'd1;
        end else begin
          v = {high_byte, b};
          fpos = '0;
          if (ph == PH_EXT_TOTAL) begin
            if (v > rem) end_body_parse();
            else begin
              exts_left = v;
              advance_extension();
            end
          end else if (v[0] || v > rem) end_body_parse();
          else if (v == 16'd0) ph = PH_COMP_LEN;
          else begin
            list_left = v;
            ph = PH_CS;
          end
        end
      end
      PH_CS: begin
        if (fpos == 2'd0) begin
          high_byte = b;
          fpos = 2'd1;
        end else begin
          v = {high_byte, b};
          fpos = '0;
          if (!grease_value(v)) push_field(KIND_CIPHER, v, ST_OK, 1'b0);
          list_left = (list_left >= 16'd2) ? list_left - 16'd2 : 16'd0;
          if (list_left == 16'd0) ph = PH_COMP_LEN;
        end
      end
      PH_EXT_HDR: begin
        exts_left = exts_left - 16'd1;
        if (fpos == 2'd0 || fpos == 2'd2) begin
          high_byte = b;
          fpos = fpos + 2'd1;
        end else if (fpos == 2'd1) begin
          ext_type = {high_byte, b};
          fpos = 2'd2;
        end else begin
          v = {high_byte, b};
          fpos = '0;
          if (v > rem || v > exts_left) end_body_parse();
          else begin
            // Open the extension: report its type unless it is GREASE
            ext_left = v;
            if (grease_value(ext_type)) ph = PH_EXT_SKIP;
            else begin
              push_field(KIND_EXTENSION, ext_type, ST_OK, 1'b0);
              if (ext_type == EXT_GROUPS && v >= 16'd2) ph = PH_EXT_LIST_LEN;
              else if ((ext_type == EXT_POINTS || ext_type == EXT_VERSIONS) && v >= 16'd1)
                ph = PH_EXT_LIST_LEN;
              else ph = PH_EXT_SKIP;
            end
            if (v == 16'd0) advance_extension();
          end
        end
      end
      PH_EXT_LIST_LEN, PH_EXT_ITEMS, PH_EXT_SKIP: begin
        ext_before = ext_left;
        if (ph == PH_EXT_LIST_LEN) begin
          if (ext_type == EXT_GROUPS && fpos == 2'd0) begin
            high_byte = b;
            fpos = 2'd1;
          end else begin
            list_left = (ext_type == EXT_GROUPS) ? {high_byte, b} : {8'h00, b};
            fpos = '0;
            ph = PH_EXT_ITEMS;
          end
        end else if (ph == PH_EXT_ITEMS) begin
          if (ext_type == EXT_POINTS) begin
            if (list_left >= 16'd1) begin
              push_field(KIND_POINT, {8'h00, b}, ST_OK, 1'b0);
              list_left = list_left - 16'd1;
            end else ph = PH_EXT_SKIP;
          end else if (fpos == 2'd0) begin
            need = (ext_type == EXT_VERSIONS) ? 16'd2 : 16'd1;
            if (list_left >= need && ext_before >= 16'd2) begin
              high_byte = b;
              fpos = 2'd1;
            end else ph = PH_EXT_SKIP;
          end else begin
            v = {high_byte, b};
            fpos = '0;
            list_left = (list_left >= 16'd2) ? list_left - 16'd2 : 16'd0;
            if (ext_type == EXT_VERSIONS) push_field(KIND_SUPP_VER, v, ST_OK, 1'b0);
            else if (!grease_value(v)) push_field(KIND_GROUP, v, ST_OK, 1'b0);
          end
        end
        ext_left  = ext_left - 16'd1;
        exts_left = exts_left - 16'd1;
        if (ext_left == 16'd0) advance_extension();
      end
      default: ;
    endcase
    // Body used up before the extension area counts as malformed
    if (rem == 24'd0 && ph < PH_EXT_HDR && err == ST_OK) end_body_parse();
  endfunction

  function automatic void parse_hello_byte(logic [7:0] b, logic last);
    status_t st;
    if (ph == PH_TYPE) begin
      if (b != HS_TYPE_CLIENT_HELLO) begin
        err = ST_NOT_CH;
        ph  = PH_DONE;
      end else begin
        ph      = PH_LEN;
        fpos    = '0;
        hdr_len = '0;
      end
    end else if (ph == PH_LEN) begin
      hdr_len = {hdr_len[15:0], b};
      fpos = fpos + 2'd1;
      if (fpos >= 2'd3) begin
        fpos = '0;
        if ({8'h00, hdr_len} > LEN_LIMIT || hdr_len == 24'd0) end_body_parse();
        else begin
          body_left = hdr_len;
          body_off  = '0;
          ph        = PH_FIXED;
        end
      end
    end else if (body_left > 24'd0) begin
      hello_body_byte(b);
    end

    // Close the message with its status and start over
    if (last) begin
      if (err == ST_NOT_CH) st = ST_NOT_CH;
      else if (ph == PH_LEN || body_left > 24'd0) st = ST_TRUNCATED;
      else st = err;
      push_field(KIND_END, 16'h0000, st, 1'b1);
      reset_parser();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void put_byte(logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  function automatic void put_random(int unsigned n);
    repeat (n) put_byte(8'($urandom));
  endfunction

  function automatic void put_word(logic [15:0] v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endfunction

  function automatic void patch_word(int unsigned pos, logic [15:0] v);
    msg_q[pos]     = v[15:8];
    msg_q[pos + 1] = v[7:0];
  endfunction

  function automatic void set_header_len(logic [23:0] n);
    msg_q[1] = n[23:16];
    msg_q[2] = n[15:8];
    msg_q[3] = n[7:0];
  endfunction

  function automatic logic [15:0] grease_or_random(int unsigned pct);
    logic [3:0] nib;
    nib = 4'($urandom);
    if ($urandom_range(99) < pct) return {nib, 4'ha, nib, 4'ha};
    return 16'($urandom);
  endfunction

  // Hand the assembled message to the driver, marking its final byte
  function automatic void flush_message();
    hello_byte_t item;
    for (int i = 0; i < msg_q.size(); i++) begin
      item.data = msg_q[i];
      item.last = (i == msg_q.size() - 1);
      pending_bytes.insert(pending_bytes.size(), item);
    end
    msg_q.delete();
  endfunction

  // Assemble a ClientHello with small random lists; some inner list lengths are off
  function automatic void build_hello();
    int unsigned sid_n;
    int unsigned n_items;
    int unsigned comp_n;
    int unsigned n_ext;
    int unsigned sel;
    int unsigned r;
    int unsigned ext_total_pos;
    int unsigned ext_pos;
    logic [15:0] etype;
    logic [15:0] grp_bytes;
    msg_q.delete();
    put_byte(HS_TYPE_CLIENT_HELLO);
    put_random(3);
    put_word(($urandom_range(99) < 70) ? 16'h0303 : 16'($urandom));
    put_random(32);

    sid_n = ($urandom_range(99) < 70) ? 0 :
            (($urandom_range(99) < 85) ? $urandom_range(1, 4) : 32);
    put_byte(8'(sid_n));
    put_random(sid_n);

    n_items = $urandom_range(0, 3);
    put_word(16'(2 * n_items));
    repeat (n_items) put_word(grease_or_random(25));

    comp_n = ($urandom_range(99) < 80) ? 1 : $urandom_range(0, 2);
    put_byte(8'(comp_n));
    put_random(comp_n);

    // Now and then leave out the extension area entirely
    if ($urandom_range(99) >= 5) begin
      ext_total_pos = msg_q.size();
      put_word(16'h0000);
      n_ext = $urandom_range(0, 4);
      repeat (n_ext) begin
        sel = $urandom_range(0, 7);
        case (sel)
          0, 7:    etype = EXT_GROUPS;
          1:       etype = EXT_POINTS;
          2:       etype = EXT_VERSIONS;
          3:       etype = 16'd16;
          4:       etype = grease_or_random(100);
          5:       etype = 16'($urandom);
          default: begin
            r = $urandom_range(0, 2);
            etype = (r == 0) ? EXT_GROUPS : ((r == 1) ? EXT_POINTS : EXT_VERSIONS);
          end
        endcase
        put_word(etype);
        ext_pos = msg_q.size();
        put_word(16'h0000);
        n_items = $urandom_range(0, 3);
        r = $urandom_range(99);
        case (sel)
          0: begin
            // Groups list, sometimes odd or claiming more than the extension holds
            grp_bytes = 16'(2 * n_items);
            if (r < 15 && n_items > 0) grp_bytes = grp_bytes - 16'd1;
            else if (r < 30) grp_bytes = grp_bytes + 16'($urandom_range(1, 4));
            put_word(grp_bytes);
            repeat (n_items) put_word(grease_or_random(25));
          end
          1: begin
            put_byte(8'(n_items + ((r < 15) ? $urandom_range(1, 2) : 0)));
            put_random(n_items);
          end
          2: begin
            put_byte(8'(2 * n_items + ((r < 15) ? 1 : 0)));
            repeat (n_items) begin
              case ($urandom_range(0, 3))
                0:       put_word(16'h0304);
                1:       put_word(16'h0303);
                2:       put_word(grease_or_random(100));
                default: put_word(16'($urandom));
              endcase
            end
          end
          3:       put_random($urandom_range(0, 5));
          4, 5:    put_random($urandom_range(0, 4));
          7:       put_random(1);
          default: ;
        endcase
        patch_word(ext_pos, 16'(msg_q.size() - ext_pos - 2));
      end
      // Short tail in the extension area that cannot hold a header
      if ($urandom_range(99) < 10) put_random($urandom_range(1, 3));
      patch_word(ext_total_pos, 16'(msg_q.size() - ext_total_pos - 2));
    end
    set_header_len(24'(msg_q.size() - 4));
  endfunction

  // Mostly clean messages; the rest truncated, padded, corrupted or noise
  function automatic void queue_random_message();
    int unsigned mode;
    int unsigned cut;
    int unsigned idx;
    int unsigned delta;
    logic [7:0]  b;
    mode = $urandom_range(99);
    build_hello();
    if (mode < 55) begin
    end else if (mode < 65) begin
      cut = $urandom_range(1, msg_q.size() - 1);
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end else if (mode < 73) begin
      put_random($urandom_range(1, 4));
    end else if (mode < 83) begin
      idx = $urandom_range(1, msg_q.size() - 1);
      msg_q[idx] = 8'($urandom);
    end else if (mode < 88) begin
      b = 8'($urandom);
      if (b == HS_TYPE_CLIENT_HELLO) b = 8'h00;
      msg_q[0] = b;
      cut = $urandom_range(1, 6);
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end else if (mode < 94) begin
      delta = $urandom_range(1, 3);
      if ($urandom_range(1) == 0) set_header_len(24'(msg_q.size() - 4 + delta));
      else set_header_len(24'(msg_q.size() - 4 - delta));
    end else begin
      msg_q.delete();
      put_byte(HS_TYPE_CLIENT_HELLO);
      put_random($urandom_range(0, 8));
    end
    flush_message();
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic note_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", results_checked, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  task automatic check_result();
    hello_field_t want;
    if (expected_fields.size() == 0) begin
      note_mismatch($sformatf("unexpected item kind %0d value %h", out_kind, out_value));
    end else begin
      want = expected_fields.pop_front();
      check_field("kind", {13'd0, out_kind}, {13'd0, want.kind});
      check_field("value", out_value, want.value);
      check_field("status", {14'd0, out_status}, {14'd0, want.status});
      check_field("last_result", {15'd0, out_last_result}, {15'd0, want.last});
    end
    results_checked++;
    if (out_last_result) messages_seen++;
  endtask

  function automatic bit quiet_window();
    return (bytes_sent >= 200) && (bytes_sent < 320);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict on every accepted item
      if (in_valid && !in_stall) begin
        parse_hello_byte(in_data_byte, in_last_byte);
        bytes_sent++;
      end
      // Offer the next item or idle; hold while stalled
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && (quiet_window() || $urandom_range(99) >= 28)) begin
          next_byte = pending_bytes.pop_front();
          in_data_byte <= next_byte.data;
          in_last_byte <= next_byte.last;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      out_stall <= !quiet_window() && ($urandom_range(99) < 28);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_fields.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_parser();

    // Directed: wrong type, wrong type with trailing bytes, cut header,
    // zero length, cut body, body too short for the fixed part, lone type byte
    msg_q = '{8'hff};
    flush_message();
    msg_q = '{8'h00, 8'h12, 8'h34};
    flush_message();
    msg_q = '{8'h01, 8'h00};
    flush_message();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h00};
    flush_message();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h05, 8'h03, 8'h03};
    flush_message();
    msg_q = '{8'h01, 8'h00, 8'h00, 8'h02, 8'h03, 8'h01};
    flush_message();
    msg_q = '{8'h01};
    flush_message();
    directed_count = pending_bytes.size();

    while (pending_bytes.size() < directed_count + RANDOM_BYTES) queue_random_message();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || in_valid || expected_fields.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes (%0d directed); checked %0d results over %0d messages",
             bytes_sent, directed_count, results_checked, messages_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches found", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/tcfp_pkg.sv
sv/tls_client_hello_fingerprint_parser.sv
bench/tb_tls_client_hello_fingerprint_parser.sv
